>>> rtl/core/display_reorder_buffer_defines.svh
// Assertion macros shared by the display reorder buffer RTL.
// Every check samples on the rising edge of aclk and is off while reset is held.
`ifndef DISPLAY_REORDER_BUFFER_DEFINES_SVH
`define DISPLAY_REORDER_BUFFER_DEFINES_SVH

// A property that must hold at every clock edge.
`define DRB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define DRB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dro_pkg.sv
package dro_pkg;

    localparam int HANDLE_W = 5;
    localparam int ORDER_W  = 32;
    localparam int DEPTH_W  = 5;
    localparam int OCC_W    = 5;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic [HANDLE_W-1:0]       handle;
        logic signed [ORDER_W-1:0] order;
    } entry_t;

    // One slot read returning from the memory during a scan.
    typedef struct packed {
        logic   valid;
        logic   first;
        entry_t entry;
    } scan_beat_t;

    function automatic logic order_less(input logic signed [ORDER_W-1:0] a,
                                        input logic signed [ORDER_W-1:0] b);
        return a < b;
    endfunction

endpackage

>>> rtl/core/dro_min_scan.sv
module dro_min_scan #(
    parameter int AW = 4
) (
    input  logic               aclk,
    input  dro_pkg::scan_beat_t beat,
    input  logic [AW-1:0]      beat_idx,
    output dro_pkg::entry_t    best_entry,
    output logic [AW-1:0]      best_idx
);

    dro_pkg::entry_t best_entry_reg;
    logic [AW-1:0]   best_idx_reg;

    // Slots arrive in ascending order, so a strict compare keeps the lowest slot on ties.
    always_ff @(posedge aclk) begin
        if (beat.valid) begin
            if (beat.first || dro_pkg::order_less(beat.entry.order, best_entry_reg.order)) begin
                best_entry_reg <= beat.entry;
                best_idx_reg   <= beat_idx;
            end
        end
    end

    assign best_entry = best_entry_reg;
    assign best_idx   = best_idx_reg;

endmodule

>>> rtl/core/display_reorder_buffer.sv
// Display reorder buffer: takes decoded pictures in decode order and releases
// them in display order, smallest picture order count first.
// Input stream: s_tuser is the command (push or flush), s_tdata carries the
// picture handle and its signed order count. Every request gives exactly one
// result on the m_ stream: m_tuser flags a released picture, m_tdata carries
// its handle, its order count and the occupancy after the request.
// cfg_data sets the reorder depth; write it only while the block is idle.
// A pass-through push, a filling push or an empty flush needs no scan. A push
// on a full buffer scans all held slots through the one read port of the slot
// memory. A flush also shifts the later slots down one per cycle.
// One request is in work at a time; the next is taken once the result sits
// in the output register, so a stalled receiver holds at most one result
// there and blocks only the completion of the following request.
// Reset empties the buffer and sets the depth to zero; the slot memory needs
// no clearing since only slots below the held count are ever read.
`include "display_reorder_buffer_defines.svh"

module display_reorder_buffer #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [4:0] picture_handle, [36:5] order_count, rest zero
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [4:0] out_handle, [36:5] out_order_count,
                                   // [41:37] occupancy, rest zero
    output logic        m_tuser,   // [0] has_picture
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic          rd_valid_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [dro_pkg::DEPTH_W-1:0] depth_cfg_reg;
    logic [CW-1:0] depth_eff;

    logic            cmd_reg, cmd_next;
    dro_pkg::entry_t new_reg, new_next;
    logic            res_has_reg, res_has_next;
    dro_pkg::entry_t res_entry_reg, res_entry_next;
    logic [dro_pkg::OCC_W-1:0] res_occ_reg, res_occ_next;

    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        out_load;

    dro_pkg::entry_t mem [SLOTS];
    dro_pkg::entry_t mem_rd_data;
    logic            mem_rd_en;
    logic [AW-1:0]   mem_rd_addr;
    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_addr;
    dro_pkg::entry_t mem_wr_data;

    dro_pkg::entry_t     in_entry;
    dro_pkg::scan_beat_t beat;
    dro_pkg::entry_t     best_entry;
    logic [AW-1:0]       best_idx;
    logic                accept;

    assign in_entry.handle = s_tdata[4:0];
    assign in_entry.order  = $signed(s_tdata[36:5]);

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign depth_eff = (32'(depth_cfg_reg) > SLOTS) ? CW'(SLOTS) : CW'(depth_cfg_reg);

    assign mem_rd_en   = ((state_reg == ST_SCAN) || (state_reg == ST_SHIFT))
                         && (ptr_reg < limit_reg);
    assign mem_rd_addr = ptr_reg[AW-1:0];

    assign beat.valid = (state_reg == ST_SCAN) && rd_valid_reg;
    assign beat.first = (rd_idx_reg == '0);
    assign beat.entry = mem_rd_data;

    dro_min_scan #(
        .AW(AW)
    ) u_min_scan (
        .aclk       (aclk),
        .beat       (beat),
        .beat_idx   (rd_idx_reg),
        .best_entry (best_entry),
        .best_idx   (best_idx)
    );

    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        held_next      = held_reg;
        ptr_next       = ptr_reg;
        limit_next     = limit_reg;
        cmd_next       = cmd_reg;
        new_next       = new_reg;
        res_has_next   = res_has_reg;
        res_entry_next = res_entry_reg;
        res_occ_next   = res_occ_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = rd_idx_reg - AW'(1);
        mem_wr_data    = mem_rd_data;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next       = s_tuser;
                    new_next       = in_entry;
                    res_has_next   = 1'b0;
                    res_entry_next = '0;
                    res_occ_next   = dro_pkg::OCC_W'(held_reg);
                    state_next     = ST_OUT;
                    priority if (depth_eff == '0) begin
                        if (s_tuser == dro_pkg::CMD_PUSH) begin
                            res_has_next   = 1'b1;
                            res_entry_next = in_entry;
                        end
                    end else if (s_tuser == dro_pkg::CMD_FLUSH && held_reg == '0) begin
                        res_has_next = 1'b0;
                    end else if (s_tuser == dro_pkg::CMD_PUSH && held_reg < depth_eff) begin
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = held_reg[AW-1:0];
                        mem_wr_data  = in_entry;
                        held_next    = held_reg + CW'(1);
                        res_occ_next = dro_pkg::OCC_W'(held_reg + CW'(1));
                    end else begin
                        ptr_next   = '0;
                        limit_next = held_reg;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (mem_rd_en) begin
                    ptr_next = ptr_reg + CW'(1);
                end else if (!rd_valid_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_has_next = 1'b1;
                if (cmd_reg == dro_pkg::CMD_FLUSH) begin
                    res_entry_next = best_entry;
                    held_next      = held_reg - CW'(1);
                    res_occ_next   = dro_pkg::OCC_W'(held_reg - CW'(1));
                    // Move every slot above the released one down by one.
                    ptr_next       = CW'(best_idx) + CW'(1);
                    limit_next     = held_reg;
                    state_next     = ST_SHIFT;
                end else begin
                    res_occ_next = dro_pkg::OCC_W'(held_reg);
                    if (dro_pkg::order_less(new_reg.order, best_entry.order)) begin
                        res_entry_next = new_reg;
                    end else begin
                        res_entry_next = best_entry;
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = best_idx;
                        mem_wr_data    = new_reg;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_SHIFT: begin
                if (rd_valid_reg) begin
                    mem_wr_en = 1'b1;
                end
                if (mem_rd_en) begin
                    ptr_next = ptr_reg + CW'(1);
                end else if (!rd_valid_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            depth_cfg_reg <= '0;
            rd_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            rd_valid_reg <= mem_rd_en;
            if (cfg_valid && cfg_ready) begin
                depth_cfg_reg <= cfg_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        limit_reg     <= limit_next;
        cmd_reg       <= cmd_next;
        new_reg       <= new_next;
        res_has_reg   <= res_has_next;
        res_entry_reg <= res_entry_next;
        res_occ_reg   <= res_occ_next;
        if (mem_rd_en) begin
            rd_idx_reg <= mem_rd_addr;
        end
        if (out_load) begin
            m_tuser_reg <= res_has_reg;
            m_tdata_reg <= {6'b0, res_occ_reg, res_entry_reg.order, res_entry_reg.handle};
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            mem_rd_data <= mem[mem_rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `DRB_ASSERT_ALWAYS(a_held_in_range, held_reg <= SLOTS, "held count exceeds slot count")
    `DRB_ASSERT_IMPL(a_scan_no_write, state_reg == ST_SCAN, !mem_wr_en,
                     "slot memory written during a scan")
    `DRB_ASSERT_IMPL(a_scan_idx_held, beat.valid, rd_idx_reg < held_reg,
                     "scan read a slot beyond the held count")
    `DRB_ASSERT_IMPL(a_shift_below_held, (state_reg == ST_SHIFT) && mem_wr_en,
                     mem_wr_addr < held_reg, "shift wrote a slot beyond the held count")
    `DRB_ASSERT_IMPL(a_decide_nonempty, state_reg == ST_DECIDE, held_reg != '0,
                     "minimum taken from an empty buffer")

endmodule
